// ===== rtl/graph_shortest_path_macros.svh =====
// ----------------------------------------------------------------------------
// graph_shortest_path assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef GRAPH_SHORTEST_PATH_MACROS_SVH
`define GRAPH_SHORTEST_PATH_MACROS_SVH

// Assert a property on every rising edge outside reset.
`define GSP_ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("graph_shortest_path assertion failed");

// Assert a property on every rising edge, reset included.
`define GSP_ASSERT(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("graph_shortest_path assertion failed");

`endif

// ===== rtl/gsp_pkg.sv =====
// ----------------------------------------------------------------------------
// gsp_pkg
// Types and constants shared by the shortest-path engine modules.
// ----------------------------------------------------------------------------
package gsp_pkg;

  localparam int NODE_AW   = 6;
  localparam int EDGE_AW   = 7;
  localparam int COORD_W   = 16;
  localparam int LEN_W     = 21;
  localparam int COST_W    = 32;
  localparam int RAD_W     = 44;
  localparam int ROOT_W    = 22;
  localparam int FRAC_BITS = 4;

  localparam logic [1:0] REQ_NODE   = 2'd0;
  localparam logic [1:0] REQ_EDGE   = 2'd1;
  localparam logic [1:0] REQ_PATH   = 2'd2;
  localparam logic [1:0] REQ_EXTENT = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADIDX  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNREACH = 2'd3;

  localparam logic [2:0] K_PLAIN   = 3'd0;
  localparam logic [2:0] K_NODE_ID = 3'd1;
  localparam logic [2:0] K_EDGE_ID = 3'd2;
  localparam logic [2:0] K_EXT     = 3'd3;
  localparam logic [2:0] K_PATH    = 3'd4;

  localparam logic [1:0] NA_A   = 2'd0;
  localparam logic [1:0] NA_B   = 2'd1;
  localparam logic [1:0] NA_IDX = 2'd2;

  localparam logic [1:0] ES_SCAN  = 2'd0;
  localparam logic [1:0] ES_PREV  = 2'd1;
  localparam logic [1:0] ES_STACK = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       node_wr;
    logic [1:0] node_sel;
    logic       cap_a;
    logic       cap_diff;
    logic       mul_first;
    logic       mul_acc;
    logic       sqrt_go;
    logic       edge_wr;
    logic       ext_acc;
    logic       idx_clr;
    logic       idx_inc;
    logic       q_init;
    logic [1:0] edge_sel;
    logic       edge_chk;
    logic       edge_upd;
    logic       eidx_inc;
    logic       settle;
    logic       cost_idx;
    logic       sel_cmp;
    logic       sel_take;
    logic       bt_init;
    logic       bt_e;
    logic       bt_n;
    logic       em_init;
    logic       em_c;
    logic       em_out;
    logic       emit;
    logic [1:0] emit_status;
    logic [2:0] emit_kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       node_full;
    logic       edge_full;
    logic       idx_bad;
    logic       few_nodes;
    logic       sqrt_done;
    logic       eidx_end;
    logic       idx_end;
    logic       idx_last;
    logic       sel_found;
    logic       sel_is_goal;
    logic       bt_done;
    logic       em_last;
  } sts_t;

endpackage

// ===== rtl/gsp_sqrt.sv =====
// ----------------------------------------------------------------------------
// gsp_sqrt
// Bit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module gsp_sqrt import gsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [REM_W+1:0]  rem_sh, trial;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    if (go) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = REM_W'(rem_sh - trial);
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(rem_sh);
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/gsp_datapath.sv =====
// ----------------------------------------------------------------------------
// gsp_datapath
// Node, edge, cost and path tables with the arithmetic around them.
// ----------------------------------------------------------------------------
module gsp_datapath import gsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic [1:0]                in_req_type,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic [NODE_AW-1:0]        in_node_a,
  input  logic [NODE_AW-1:0]        in_node_b,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [6:0]                out_assigned_id,
  output logic [6:0]                out_edge_index,
  output logic [5:0]                out_from_node,
  output logic [5:0]                out_to_node,
  output logic [COST_W-1:0]         out_path_cost,
  output logic [15:0]               out_extent_x,
  output logic [15:0]               out_extent_y,
  output logic                      out_last
);

  localparam int NNODE = 1 << NODE_AW;
  localparam int NEDGE = 1 << EDGE_AW;

  // request
  logic [1:0]                req_type_r;
  logic signed [COORD_W-1:0] req_x_r, req_y_r;
  logic [NODE_AW-1:0]        req_a_r, req_b_r;
  logic [NODE_AW:0]          node_count_r;
  logic [EDGE_AW:0]          edge_count_r;

  // memories
  logic signed [COORD_W-1:0] node_xs [NNODE];
  logic signed [COORD_W-1:0] node_ys [NNODE];
  logic [NODE_AW-1:0]        edge_a_mem [NEDGE];
  logic [NODE_AW-1:0]        edge_b_mem [NEDGE];
  logic [LEN_W-1:0]          edge_len_mem [NEDGE];
  logic [COST_W-1:0]         cost_mem [NNODE];
  logic [EDGE_AW-1:0]        prev_mem [NNODE];
  logic [EDGE_AW-1:0]        stack_mem [NNODE-1];

  logic signed [COORD_W-1:0] x_rd, y_rd;
  logic [NODE_AW-1:0]        ea_rd, eb_rd;
  logic [LEN_W-1:0]          len_rd;
  logic [COST_W-1:0]         cost_rd;
  logic [EDGE_AW-1:0]        prev_rd, stack_rd;

  logic [NODE_AW-1:0] node_ra, cost_ra, cost_wa, nb;
  logic [EDGE_AW-1:0] edge_ra;
  logic [COST_W-1:0]  cost_wd;
  logic               cost_we, upd_ok;

  // edge build
  logic signed [COORD_W-1:0] xa_r, ya_r;
  logic signed [COORD_W:0]   dx_r, dy_r, mul_in;
  logic signed [2*COORD_W+1:0] prod;
  logic [2*COORD_W+2:0]      sq_r;
  logic                      sq_done;
  logic [ROOT_W-1:0]         root;

  // extent
  logic signed [COORD_W-1:0] minx_r, maxx_r, miny_r, maxy_r;
  logic [COORD_W:0]          ext_dx, ext_dy;

  // search
  logic [NNODE-1:0]   reached_r, settled_r;
  logic [NODE_AW-1:0] cur_r, nb_r, sel_idx_r;
  logic [COST_W-1:0]  cur_cost_r, nc_r, sel_cost_r;
  logic [COST_W:0]    nc_sum;
  logic               inc_r, sel_found_r;
  logic [EDGE_AW:0]   eidx_r;
  logic [NODE_AW:0]   idx_r;
  logic [NODE_AW-1:0] depth_r, em_i_r;
  logic [NODE_AW-1:0] stack_ra;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_type_r <= in_req_type;
      req_x_r    <= in_coord_x;
      req_y_r    <= in_coord_y;
      req_a_r    <= in_node_a;
      req_b_r    <= in_node_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      edge_count_r <= '0;
    end else begin
      if (cmd.node_wr) node_count_r <= node_count_r + 1'b1;
      if (cmd.edge_wr) edge_count_r <= edge_count_r + 1'b1;
    end
  end

  // node tables
  always_comb begin
    case (cmd.node_sel)
      NA_A:    node_ra = req_a_r;
      NA_B:    node_ra = req_b_r;
      NA_IDX:  node_ra = idx_r[NODE_AW-1:0];
      default: node_ra = req_a_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.node_wr) begin
      node_xs[node_count_r[NODE_AW-1:0]] <= req_x_r;
      node_ys[node_count_r[NODE_AW-1:0]] <= req_y_r;
    end
    x_rd <= node_xs[node_ra];
    y_rd <= node_ys[node_ra];
  end

  // edge tables
  always_comb begin
    case (cmd.edge_sel)
      ES_SCAN:  edge_ra = eidx_r[EDGE_AW-1:0];
      ES_PREV:  edge_ra = prev_rd;
      ES_STACK: edge_ra = stack_rd;
      default:  edge_ra = eidx_r[EDGE_AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_wr) begin
      edge_a_mem[edge_count_r[EDGE_AW-1:0]]   <= req_a_r;
      edge_b_mem[edge_count_r[EDGE_AW-1:0]]   <= req_b_r;
      edge_len_mem[edge_count_r[EDGE_AW-1:0]] <= root[LEN_W-1:0];
    end
    ea_rd  <= edge_a_mem[edge_ra];
    eb_rd  <= edge_b_mem[edge_ra];
    len_rd <= edge_len_mem[edge_ra];
  end

  // far end of the edge just read, seen from the current node
  assign nb     = (ea_rd == cur_r) ? eb_rd : ea_rd;
  assign nc_sum = {1'b0, cur_cost_r} + {{(COST_W+1-LEN_W){1'b0}}, len_rd};

  // cost table
  assign cost_ra = cmd.cost_idx ? idx_r[NODE_AW-1:0] : nb;
  assign upd_ok  = cmd.edge_upd && inc_r && !settled_r[nb_r] &&
                   (!reached_r[nb_r] || (cost_rd > nc_r));
  assign cost_we = cmd.q_init || upd_ok;
  assign cost_wa = cmd.q_init ? req_a_r : nb_r;
  assign cost_wd = cmd.q_init ? '0 : nc_r;

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    cost_rd <= cost_mem[cost_ra];
  end

  always_ff @(posedge clk) begin
    if (upd_ok) prev_mem[nb_r] <= eidx_r[EDGE_AW-1:0];
    prev_rd <= prev_mem[cur_r];
  end

  assign stack_ra = NODE_AW'(depth_r - em_i_r - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.bt_e) stack_mem[depth_r] <= prev_rd;
    stack_rd <= stack_mem[stack_ra];
  end

  // edge length: squares through one multiplier, then the root unit
  assign mul_in = cmd.mul_acc ? dy_r : dx_r;
  assign prod   = mul_in * mul_in;

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      xa_r <= x_rd;
      ya_r <= y_rd;
    end
    if (cmd.cap_diff) begin
      dx_r <= (COORD_W+1)'(xa_r) - (COORD_W+1)'(x_rd);
      dy_r <= (COORD_W+1)'(ya_r) - (COORD_W+1)'(y_rd);
    end
    if (cmd.mul_first) sq_r <= {1'b0, prod};
    if (cmd.mul_acc)   sq_r <= sq_r + {1'b0, prod};
  end

  gsp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.sqrt_go),
    .radicand (RAD_W'({sq_r, {(2*FRAC_BITS){1'b0}}})),
    .done     (sq_done),
    .root     (root)
  );

  // bounding box
  always_ff @(posedge clk) begin
    if (cmd.ext_acc) begin
      if (idx_r == '0) begin
        minx_r <= x_rd; maxx_r <= x_rd;
        miny_r <= y_rd; maxy_r <= y_rd;
      end else begin
        if (x_rd < minx_r) minx_r <= x_rd;
        if (x_rd > maxx_r) maxx_r <= x_rd;
        if (y_rd < miny_r) miny_r <= y_rd;
        if (y_rd > maxy_r) maxy_r <= y_rd;
      end
    end
  end

  assign ext_dx = (COORD_W+1)'(maxx_r) - (COORD_W+1)'(minx_r);
  assign ext_dy = (COORD_W+1)'(maxy_r) - (COORD_W+1)'(miny_r);

  // search registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r <= '0;
      settled_r <= '0;
    end else begin
      if (cmd.q_init) begin
        reached_r          <= '0;
        settled_r          <= '0;
        reached_r[req_a_r] <= 1'b1;
      end
      if (upd_ok)     reached_r[nb_r]  <= 1'b1;
      if (cmd.settle) settled_r[cur_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      cur_r      <= req_a_r;
      cur_cost_r <= '0;
    end
    if (cmd.sel_take) begin
      cur_r      <= sel_idx_r;
      cur_cost_r <= sel_cost_r;
    end
    if (cmd.bt_init) cur_r <= req_b_r;
    if (cmd.bt_n)    cur_r <= nb;
    if (cmd.em_init) cur_r <= req_a_r;
    if (cmd.em_out)  cur_r <= nb_r;

    if (cmd.q_init || cmd.sel_take) eidx_r <= '0;
    else if (cmd.eidx_inc)          eidx_r <= eidx_r + 1'b1;

    if (cmd.idx_clr || cmd.settle) idx_r <= '0;
    else if (cmd.idx_inc)          idx_r <= idx_r + 1'b1;

    if (cmd.edge_chk || cmd.em_c) nb_r <= nb;
    if (cmd.edge_chk) begin
      inc_r <= (ea_rd == cur_r) || (eb_rd == cur_r);
      nc_r  <= nc_sum[COST_W] ? '1 : nc_sum[COST_W-1:0];
    end

    if (cmd.settle) sel_found_r <= 1'b0;
    if (cmd.sel_cmp && reached_r[idx_r[NODE_AW-1:0]] &&
        !settled_r[idx_r[NODE_AW-1:0]] && (!sel_found_r || cost_rd < sel_cost_r)) begin
      sel_found_r <= 1'b1;
      sel_idx_r   <= idx_r[NODE_AW-1:0];
      sel_cost_r  <= cost_rd;
    end

    if (cmd.bt_init)   depth_r <= '0;
    else if (cmd.bt_n) depth_r <= depth_r + 1'b1;

    if (cmd.em_init)     em_i_r <= '0;
    else if (cmd.em_out) em_i_r <= em_i_r + 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      out_status      <= cmd.emit_status;
      out_assigned_id <= '0;
      out_edge_index  <= '0;
      out_from_node   <= '0;
      out_to_node     <= '0;
      out_path_cost   <= '0;
      out_extent_x    <= '0;
      out_extent_y    <= '0;
      out_last        <= 1'b1;
      case (cmd.emit_kind)
        K_NODE_ID: out_assigned_id <= 7'(node_count_r);
        K_EDGE_ID: out_assigned_id <= edge_count_r[EDGE_AW-1:0];
        K_EXT: begin
          out_extent_x <= ext_dx[15:0];
          out_extent_y <= ext_dy[15:0];
        end
        K_PATH: begin
          out_edge_index <= 7'(em_i_r);
          out_from_node  <= cur_r;
          out_to_node    <= nb_r;
          out_path_cost  <= cost_rd;
          out_last       <= sts.em_last;
        end
        default: ;
      endcase
    end
  end

  // status to the controller
  always_comb begin
    sts.req_type    = req_type_r;
    sts.node_full   = node_count_r[NODE_AW];
    sts.edge_full   = edge_count_r[EDGE_AW];
    sts.idx_bad     = ({1'b0, req_a_r} >= node_count_r) ||
                      ({1'b0, req_b_r} >= node_count_r) || (req_a_r == req_b_r);
    sts.few_nodes   = node_count_r < (NODE_AW+1)'(2);
    sts.sqrt_done   = sq_done;
    sts.eidx_end    = eidx_r == edge_count_r;
    sts.idx_end     = idx_r == node_count_r;
    sts.idx_last    = (idx_r + 1'b1) == node_count_r;
    sts.sel_found   = sel_found_r;
    sts.sel_is_goal = sel_idx_r == req_b_r;
    sts.bt_done     = (cur_r == req_a_r) || (depth_r == NODE_AW'(NNODE - 1));
    sts.em_last     = ({1'b0, em_i_r} + 1'b1) == {1'b0, depth_r};
  end

endmodule

// ===== rtl/gsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsp_ctrl
// Request sequencer: decodes a transaction and steps the datapath.
// ----------------------------------------------------------------------------
module gsp_ctrl import gsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DECODE   = 5'd1;
  localparam logic [4:0] S_RD_A     = 5'd2;
  localparam logic [4:0] S_RD_B     = 5'd3;
  localparam logic [4:0] S_DIFF     = 5'd4;
  localparam logic [4:0] S_MULX     = 5'd5;
  localparam logic [4:0] S_MULY     = 5'd6;
  localparam logic [4:0] S_SQ_GO    = 5'd7;
  localparam logic [4:0] S_SQ_WAIT  = 5'd8;
  localparam logic [4:0] S_EDGE_WR  = 5'd9;
  localparam logic [4:0] S_EXT_RD   = 5'd10;
  localparam logic [4:0] S_EXT_ACC  = 5'd11;
  localparam logic [4:0] S_EXT_OUT  = 5'd12;
  localparam logic [4:0] S_SCAN_RD  = 5'd13;
  localparam logic [4:0] S_SCAN_CHK = 5'd14;
  localparam logic [4:0] S_SCAN_UPD = 5'd15;
  localparam logic [4:0] S_SETTLE   = 5'd16;
  localparam logic [4:0] S_SEL_RD   = 5'd17;
  localparam logic [4:0] S_SEL_CMP  = 5'd18;
  localparam logic [4:0] S_SEL_END  = 5'd19;
  localparam logic [4:0] S_BT_INIT  = 5'd20;
  localparam logic [4:0] S_BT_RD    = 5'd21;
  localparam logic [4:0] S_BT_E     = 5'd22;
  localparam logic [4:0] S_BT_N     = 5'd23;
  localparam logic [4:0] S_EM_INIT  = 5'd24;
  localparam logic [4:0] S_EM_RD    = 5'd25;
  localparam logic [4:0] S_EM_E     = 5'd26;
  localparam logic [4:0] S_EM_C     = 5'd27;
  localparam logic [4:0] S_EM_OUT   = 5'd28;

  logic [4:0] state_r, state_nxt;

  assign busy = state_r != S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (sts.req_type)
          REQ_NODE: begin
            cmd.emit = 1'b1;
            if (sts.node_full) begin
              cmd.emit_status = ST_FULL;
            end else begin
              cmd.node_wr   = 1'b1;
              cmd.emit_kind = K_NODE_ID;
            end
          end
          REQ_EDGE: begin
            if (sts.idx_bad) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_BADIDX;
            end else if (sts.edge_full) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_FULL;
            end else begin
              state_nxt = S_RD_A;
            end
          end
          REQ_PATH: begin
            if (sts.idx_bad) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_BADIDX;
            end else begin
              cmd.q_init = 1'b1;
              state_nxt  = S_SCAN_RD;
            end
          end
          default: begin
            if (sts.few_nodes) begin
              cmd.emit = 1'b1;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_EXT_RD;
            end
          end
        endcase
      end
      S_RD_A: begin
        cmd.node_sel = NA_A;
        state_nxt    = S_RD_B;
      end
      S_RD_B: begin
        cmd.node_sel = NA_B;
        cmd.cap_a    = 1'b1;
        state_nxt    = S_DIFF;
      end
      S_DIFF: begin
        cmd.cap_diff = 1'b1;
        state_nxt    = S_MULX;
      end
      S_MULX: begin
        cmd.mul_first = 1'b1;
        state_nxt     = S_MULY;
      end
      S_MULY: begin
        cmd.mul_acc = 1'b1;
        state_nxt   = S_SQ_GO;
      end
      S_SQ_GO: begin
        cmd.sqrt_go = 1'b1;
        state_nxt   = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (sts.sqrt_done) state_nxt = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        cmd.edge_wr   = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_kind = K_EDGE_ID;
        state_nxt     = S_IDLE;
      end
      S_EXT_RD: begin
        cmd.node_sel = NA_IDX;
        state_nxt    = S_EXT_ACC;
      end
      S_EXT_ACC: begin
        cmd.ext_acc = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = sts.idx_last ? S_EXT_OUT : S_EXT_RD;
      end
      S_EXT_OUT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = K_EXT;
        state_nxt     = S_IDLE;
      end
      S_SCAN_RD: begin
        cmd.edge_sel = ES_SCAN;
        state_nxt    = sts.eidx_end ? S_SETTLE : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.edge_chk = 1'b1;
        state_nxt    = S_SCAN_UPD;
      end
      S_SCAN_UPD: begin
        cmd.edge_upd = 1'b1;
        cmd.eidx_inc = 1'b1;
        state_nxt    = S_SCAN_RD;
      end
      S_SETTLE: begin
        cmd.settle = 1'b1;
        state_nxt  = S_SEL_RD;
      end
      S_SEL_RD: begin
        cmd.cost_idx = 1'b1;
        state_nxt    = sts.idx_end ? S_SEL_END : S_SEL_CMP;
      end
      S_SEL_CMP: begin
        cmd.sel_cmp = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_SEL_RD;
      end
      S_SEL_END: begin
        if (!sts.sel_found) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_UNREACH;
          state_nxt       = S_IDLE;
        end else begin
          cmd.sel_take = 1'b1;
          state_nxt    = sts.sel_is_goal ? S_BT_INIT : S_SCAN_RD;
        end
      end
      S_BT_INIT: begin
        cmd.bt_init = 1'b1;
        state_nxt   = S_BT_RD;
      end
      S_BT_RD: begin
        state_nxt = sts.bt_done ? S_EM_INIT : S_BT_E;
      end
      S_BT_E: begin
        cmd.bt_e     = 1'b1;
        cmd.edge_sel = ES_PREV;
        state_nxt    = S_BT_N;
      end
      S_BT_N: begin
        cmd.bt_n  = 1'b1;
        state_nxt = S_BT_RD;
      end
      S_EM_INIT: begin
        cmd.em_init = 1'b1;
        state_nxt   = S_EM_RD;
      end
      S_EM_RD: begin
        state_nxt = S_EM_E;
      end
      S_EM_E: begin
        cmd.edge_sel = ES_STACK;
        state_nxt    = S_EM_C;
      end
      S_EM_C: begin
        cmd.em_c  = 1'b1;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd.em_out    = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_kind = K_PATH;
        state_nxt     = sts.em_last ? S_IDLE : S_EM_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/graph_shortest_path.sv =====
// ----------------------------------------------------------------------------
// graph_shortest_path
// Planar graph store with Dijkstra path search and bounding-box query.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  request  | start / busy           | in_req_type, in_coord_x/y, in_node_a/b
//  result   | out_valid (one cycle)  | out_status ... out_last
//
// A transaction is taken when start is high and busy is low; busy stays
// high until the last result has been issued.
// Add edge waits on the bit-serial square root (one root bit per cycle).
// Extent reads every stored node once. Path query: per settled node an
// edge scan and a minimum search (they share single-port tables), then
// a backtrack over the path edges and one result per path edge. No
// clearing pass after reset.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module graph_shortest_path import gsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_req_type,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic [NODE_AW-1:0]        in_node_a,
  input  logic [NODE_AW-1:0]        in_node_b,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [6:0]                out_assigned_id,
  output logic [6:0]                out_edge_index,
  output logic [5:0]                out_from_node,
  output logic [5:0]                out_to_node,
  output logic [COST_W-1:0]         out_path_cost,
  output logic [15:0]               out_extent_x,
  output logic [15:0]               out_extent_y,
  output logic                      out_last
);

  // command bundle from the sequencer, status back from the tables
  cmd_t cmd;
  sts_t sts;

  gsp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  gsp_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_node_a       (in_node_a),
    .in_node_b       (in_node_b),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_assigned_id (out_assigned_id),
    .out_edge_index  (out_edge_index),
    .out_from_node   (out_from_node),
    .out_to_node     (out_to_node),
    .out_path_cost   (out_path_cost),
    .out_extent_x    (out_extent_x),
    .out_extent_y    (out_extent_y),
    .out_last        (out_last)
  );

endmodule

// ===== rtl/gsp_checker.sv =====
// ----------------------------------------------------------------------------
// gsp_checker
// Port-level checks on the shortest-path engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "graph_shortest_path_macros.svh"

module gsp_checker import gsp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic       out_last
);

  `GSP_ASSERT(a_reset_quiet, clk, !rst_n |=> !out_valid && !busy)
  `GSP_ASSERT_RST(a_accept_busy, clk, rst_n, start && !busy |=> busy)
  `GSP_ASSERT_RST(a_error_last, clk, rst_n, out_valid && out_status != ST_OK |-> out_last)
  `GSP_ASSERT_RST(a_last_gap, clk, rst_n, out_valid && out_last |=> !out_valid)
  `GSP_ASSERT_RST(a_more_busy, clk, rst_n, out_valid && !out_last |=> busy)

endmodule

bind graph_shortest_path gsp_checker u_gsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_last   (out_last)
);
